@@ design/sce_pkg.sv @@
// Shared types and constants of the sigmoid cross-entropy loss block.
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_VALUE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PER_SAMPLE_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_WEIGHT      = 3'd5;

    localparam logic [1:0] NORM_FULL  = 2'd0;
    localparam logic [1:0] NORM_VALID = 2'd1;
    localparam logic [1:0] NORM_BATCH = 2'd2;
    localparam logic [1:0] NORM_NONE  = 2'd3;

    localparam logic ACT_FWD   = 1'b0;
    localparam logic ACT_BWD   = 1'b1;
    localparam logic KIND_LOSS = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    localparam int SUM_W      = 48;
    localparam int NORM_W     = 32;
    localparam int DIV_NUM_W  = 49;
    localparam int DIV_DEN_W  = 41;
    localparam int PROD_W     = 41;

    typedef struct packed {
        logic               ignore_enable;
        logic signed [8:0]  ignore_value;
        logic [1:0]         norm_mode;
        logic [15:0]        batch_size;
        logic [15:0]        per_sample_count;
        logic signed [15:0] grad_weight;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] logit;
        logic signed [15:0] target;
        logic               last;
        logic               ignored;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ design/sce_front.sv @@
// Front part: takes input words, flags ignored targets and queues them.
`timescale 1ns / 1ps
`default_nettype none

module sce_front import sce_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic signed [15:0] logit,
    input  wire logic signed [15:0] target,
    input  wire logic               last,
    input  wire cfg_t               cfg,
    input  wire logic               pop,
    output item_t                   head,
    output logic                    empty
);

    logic signed [8:0] y_int;
    logic              push;
    item_t             new_item;
    item_t             q_mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;

    // Integer part of the target, truncated toward zero.
    assign y_int = {target[15], target[15:8]}
                 + {8'd0, target[15] & (|target[7:0])};

    always_comb
    begin
        new_item.action  = action;
        new_item.logit   = logit;
        new_item.target  = target;
        new_item.last    = last;
        new_item.ignored = cfg.ignore_enable & (y_int == cfg.ignore_value);
    end

    assign in_stall = cnt_reg[1];
    assign empty    = (cnt_reg == 2'd0);
    assign push     = in_valid & ~in_stall;
    assign head     = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop & ~empty);
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop & ~empty};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ design/sce_rom.sv @@
// Softplus and sigmoid tables over |x|, with registered read.
`timescale 1ns / 1ps
`default_nettype none

module sce_rom #(
    parameter int DEPTH = 1024
)
(
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    output logic [16:0]                   sp_q,
    output logic [16:0]                   sg_q
);

    typedef logic [16:0] rom_t [DEPTH];

    // Unsigned long division, only used while the tables are built.
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned qt;
        longint unsigned rm;
        qt = 0;
        rm = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rm = {rm[62:0], n[b]};
            if (rm >= d)
            begin
                rm    = rm - d;
                qt[b] = 1'b1;
            end
        end
        return qt;
    endfunction

    function automatic rom_t build_rom(input logic want_sp);
        longint unsigned h;
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned acc;
        longint signed   r;
        longint unsigned k;
        int              i;
        rom_t            tab;
        h   = udiv(64'h4_0000_0000, longint'(DEPTH));
        mag = 64'd1 << 30;
        r   = longint'(64'd1 << 30);
        e   = 64'd1 << 30;
        for (k = 1; k <= 24; k++)
        begin
            mag = udiv((mag * h) >> 30, k);
            if (k[0]) r = r - longint'(mag);
            else      r = r + longint'(mag);
        end
        for (i = 0; i < DEPTH; i++)
        begin
            if (i > 0) e = (e * longint'(unsigned'(r)) + (64'd1 << 29)) >> 30;
            if (want_sp)
            begin
                den = (64'd1 << 31) + e;
                z   = udiv((e << 30) + (den >> 1), den);
                z2  = (z * z + (64'd1 << 29)) >> 30;
                p   = z;
                acc = 0;
                for (k = 1; k <= 39; k += 2)
                begin
                    acc = acc + udiv(p, k);
                    p   = (p * z2) >> 30;
                end
                tab[i] = 17'((2 * acc + (64'd1 << 13)) >> 14);
            end
            else
            begin
                den    = (64'd1 << 30) + e;
                tab[i] = 17'(udiv((64'd1 << 46) + (den >> 1), den));
            end
        end
        return tab;
    endfunction

    localparam rom_t SP_TAB = build_rom(1'b1);
    localparam rom_t SG_TAB = build_rom(1'b0);

    always_ff @(posedge clk)
    begin
        sp_q <= SP_TAB[addr];
        sg_q <= SG_TAB[addr];
    end

endmodule

`default_nettype wire

@@ design/sce_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sce_div import sce_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            cnt_next  = CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.quo  = quo_reg;
    end

endmodule

`default_nettype wire

@@ design/sce_back.sv @@
// Back part: table lookup, loss accumulation, normalizing divide and output.
`timescale 1ns / 1ps
`default_nettype none

module sce_back import sce_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1048576,
    parameter int TABLE_DEPTH  = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               empty,
    input  wire item_t              head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    kind,
    output logic signed [31:0]      value,
    output logic                    final_res
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int PW = 17 + $clog2(TABLE_DEPTH + 1);
    localparam int VW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROM  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]             state_reg, state_next;
    item_t                  item_reg;
    logic                   idx_ok_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [VW-1:0]          valid_cnt_reg, valid_cnt_next;
    logic [NORM_W-1:0]      norm_reg, norm_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [16:0]            sp_reg;
    logic                   neg_reg;
    logic signed [31:0]     res_reg;
    logic                   res_kind_reg;
    logic                   res_final_reg;
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic signed [31:0]     out_value_reg;
    logic                   out_final_reg;

    logic [16:0]            head_ax;
    logic [PW-1:0]          head_scaled;
    logic [PW-13:0]         head_idx;
    logic [16:0]            sp_q, sg_q;
    logic [16:0]            sp_eff, sg_raw, sg_eff;
    logic                   pos;
    logic signed [24:0]     mul_a;
    logic signed [15:0]     mul_b;
    logic signed [24:0]     diff;
    logic signed [24:0]     fac;
    logic [SUM_W:0]         sum49;
    logic [PROD_W-1:0]      prod_mag;
    logic [SUM_W-1:0]       sum_mag;
    logic [NORM_W-1:0]      n_sel, n_fin;
    logic [DIV_NUM_W-1:0]   q;
    logic signed [31:0]     q_sat;
    logic                   out_load;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // Table index from the queue head so the read lines up with the pop.
    assign head_ax     = head.logit[15] ? (17'd0 - {1'b1, head.logit})
                                        : {1'b0, head.logit};
    assign head_scaled = PW'(head_ax) * PW'(TABLE_DEPTH);
    assign head_idx    = head_scaled[PW-1:12];
    assign pop         = (state_reg == S_IDLE) & ~empty;

    sce_rom #(
        .DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (head_idx[IW-1:0]),
        .sp_q (sp_q),
        .sg_q (sg_q)
    );

    sce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Lookup results and the single shared multiplier.
    always_comb
    begin
        pos    = ~item_reg.logit[15];
        sp_eff = idx_ok_reg ? sp_q : 17'd0;
        sg_raw = idx_ok_reg ? sg_q : 17'd65536;
        sg_eff = pos ? sg_raw : (17'd65536 - sg_raw);
        diff   = $signed({8'd0, sg_eff})
               - $signed({item_reg.target[15], item_reg.target, 8'd0});
        fac    = (pos ? 25'sd256 : 25'sd0)
               - $signed({{9{item_reg.target[15]}}, item_reg.target});
        if (item_reg.action == ACT_FWD)
        begin
            mul_a = fac;
            mul_b = item_reg.logit;
        end
        else
        begin
            mul_a = diff;
            mul_b = cfg.grad_weight;
        end
    end

    always_comb
    begin
        sum49    = {sum_reg[SUM_W-1], sum_reg} + {{8{prod_reg[PROD_W-1]}}, prod_reg}
                 + {32'd0, sp_reg};
        prod_mag = prod_reg[PROD_W-1] ? (PROD_W'(0) - prod_reg) : prod_reg;
        sum_mag  = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
        case (cfg.norm_mode)
            NORM_FULL:  n_sel = cfg.batch_size * cfg.per_sample_count;
            NORM_VALID: n_sel = NORM_W'(valid_cnt_reg);
            NORM_BATCH: n_sel = NORM_W'(cfg.batch_size);
            default:    n_sel = NORM_W'(1);
        endcase
        n_fin = (n_sel == '0) ? NORM_W'(1) : n_sel;
        q     = div_rsp.quo;
        if (neg_reg)
        begin
            q_sat = (q > DIV_NUM_W'(64'h8000_0000)) ? 32'sh8000_0000
                                                     : $signed(32'd0 - q[31:0]);
        end
        else
        begin
            q_sat = (q > DIV_NUM_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                     : $signed(q[31:0]);
        end
    end

    assign out_load = (state_reg == S_OUT) & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        valid_cnt_next = valid_cnt_reg;
        norm_next      = norm_reg;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty) state_next = S_ROM;
            end
            S_ROM:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (item_reg.action == ACT_FWD)
                begin
                    if (!item_reg.ignored)
                    begin
                        if (sum49[SUM_W] != sum49[SUM_W-1])
                        begin
                            sum_next = sum49[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                    : {1'b0, {(SUM_W-1){1'b1}}};
                        end
                        else
                        begin
                            sum_next = sum49[SUM_W-1:0];
                        end
                        if (valid_cnt_reg < VW'(MAX_ELEMENTS))
                        begin
                            valid_cnt_next = valid_cnt_reg + VW'(1);
                        end
                    end
                    state_next = item_reg.last ? S_NORM : S_IDLE;
                end
                else if (item_reg.ignored)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(prod_mag) + DIV_NUM_W'({norm_reg, 7'd0});
                    div_req.den   = {1'b0, norm_reg, 8'd0};
                    state_next    = S_DIV;
                end
            end
            S_NORM:
            begin
                norm_next      = n_fin;
                div_req.start  = 1'b1;
                div_req.num    = DIV_NUM_W'(sum_mag) + DIV_NUM_W'(n_fin >> 1);
                div_req.den    = DIV_DEN_W'(n_fin);
                sum_next       = '0;
                valid_cnt_next = '0;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done) state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg   <= head;
            idx_ok_reg <= (head_idx < (PW-12)'(TABLE_DEPTH));
        end
        if (state_reg == S_ROM)
        begin
            prod_reg <= PROD_W'(mul_a * mul_b);
            sp_reg   <= sp_eff;
        end
        if (state_reg == S_EXEC)
        begin
            neg_reg       <= prod_reg[PROD_W-1];
            res_reg       <= '0;
            res_kind_reg  <= KIND_GRAD;
            res_final_reg <= 1'b0;
        end
        if (state_reg == S_NORM)
        begin
            neg_reg       <= sum_reg[SUM_W-1];
            res_kind_reg  <= KIND_LOSS;
            res_final_reg <= 1'b1;
        end
        if ((state_reg == S_DIV) && div_rsp.done)
        begin
            res_reg <= q_sat;
        end
        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_value_reg <= res_reg;
            out_final_reg <= res_final_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            valid_cnt_reg <= '0;
            norm_reg      <= NORM_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            valid_cnt_reg <= valid_cnt_next;
            norm_reg      <= norm_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign value     = out_value_reg;
    assign final_res = out_final_reg;

`ifndef NO_ASSERTIONS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_reg != '0)
        else $error("normalizer is zero");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");
    a_pop_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_ROM))
        else $error("popped word not looked up");
`endif

endmodule

`default_nettype wire

@@ design/sigmoid_cross_entropy_loss_top.sv @@
// Top level of the sigmoid cross-entropy loss block.
`timescale 1ns / 1ps
`default_nettype none

// Sigmoid cross-entropy loss over a stream of Q8.8 (logit, target) words.
// Input channel: in_valid/in_stall with action, logit, target and last.
// A forward word not ignored adds its element loss to a running sum; the
// forward word marked last closes the pass and gives one loss word (kind 0,
// final_res 1). A backward word always produces one gradient word (kind 1).
// Output channel: out_valid/out_stall with kind, value (Q16.16) and final_res.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and writes act at once. Write only while the block is idle.
// Flow: a word waits in a two-entry queue, then passes the back end steps
// of table read, multiply and accumulate, which end a forward element that
// is not last. The last forward word and every backward word not ignored go
// through the 49-step serial divider, which sets the rate of the gradient
// stream; an ignored backward word skips the divider and goes to the output.
// When the receiver stalls, the result stays in the output register, the
// back end holds its next result, and the queue keeps taking words until it
// fills. Reset clears the sum, the element count and the queue, and sets the
// normalizer to one and the registers to their defaults.

module sigmoid_cross_entropy_loss_top import sce_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1048576,
    parameter int TABLE_DEPTH  = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic signed [15:0]    logit,
    input  wire logic signed [15:0]    target,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic signed [31:0]         value,
    output logic                       final_res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    item_t head;
    logic  empty;
    logic  pop;

    assign cfg_ready = 1'b1;

    // Register file; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ignore_enable    <= 1'b0;
            cfg_reg.ignore_value     <= -9'sd1;
            cfg_reg.norm_mode        <= NORM_BATCH;
            cfg_reg.batch_size       <= 16'd1;
            cfg_reg.per_sample_count <= 16'd1;
            cfg_reg.grad_weight      <= 16'sd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IGNORE_ENABLE:    cfg_reg.ignore_enable    <= cfg_data[0];
                REG_IGNORE_VALUE:     cfg_reg.ignore_value     <= $signed(cfg_data[8:0]);
                REG_NORM_MODE:        cfg_reg.norm_mode        <= cfg_data[1:0];
                REG_BATCH_SIZE:       cfg_reg.batch_size       <= cfg_data;
                REG_PER_SAMPLE_COUNT: cfg_reg.per_sample_count <= cfg_data;
                REG_GRAD_WEIGHT:      cfg_reg.grad_weight      <= $signed(cfg_data);
                default:              ;
            endcase
        end
    end

    sce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .logit    (logit),
        .target   (target),
        .last     (last),
        .cfg      (cfg_reg),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    sce_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .final_res (final_res)
    );

endmodule

`default_nettype wire

@@ verif/tb_sigmoid_cross_entropy_loss_top.sv @@
// Self-checking testbench for the sigmoid cross-entropy loss block.
`timescale 1ns / 1ps

module tb_sigmoid_cross_entropy_loss_top import sce_pkg::*;
    ;

    localparam int MAX_ELEM = 1048576;
    localparam int ROM_DEPTH = 1024;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
    localparam int DRAIN_CYCLES = 150;

    // One expected output word.
    typedef struct {
        logic               kind;
        logic signed [31:0] value;
        logic               final_res;
    } loss_word_t;

    // The scoreboard carries its own copy of the registers, the running sum
    // and count, the normalizer of the last pass and both lookup tables.
    class loss_scoreboard;
        bit                 ign_en;
        logic signed [8:0]  ign_val;
        logic [1:0]         mode;
        logic [15:0]        batch;
        logic [15:0]        per_sample;
        logic signed [15:0] weight;
        longint             sum;
        longint             count;
        longint             norm;
        longint             softplus_tab[ROM_DEPTH];
        longint             sigmoid_tab[ROM_DEPTH];
        loss_word_t         expected_words[$];
        int                 errors;

        function new();
            longint unsigned h, mag, e, den, z, z2, p, acc;
            longint r;
            h = (64'd1 << 34) / ROM_DEPTH;
            mag = 64'd1 << 30;
            r = 64'sd1 << 30;
            e = 64'd1 << 30;
            for (int k = 1; k <= 24; k++)
            begin
                mag = ((mag * h) >> 30) / k;
                if (k % 2 == 1) r -= longint'(mag); else r += longint'(mag);
            end
            for (int i = 0; i < ROM_DEPTH; i++)
            begin
                if (i > 0) e = (e * longint'(r) + (64'd1 << 29)) >> 30;
                den = (64'd1 << 31) + e;
                z = ((e << 30) + (den >> 1)) / den;
                z2 = (z * z + (64'd1 << 29)) >> 30;
                p = z;
                acc = 0;
                for (int k = 1; k <= 39; k += 2)
                begin
                    acc += p / k;
                    p = (p * z2) >> 30;
                end
                softplus_tab[i] = longint'((2 * acc + (64'd1 << 13)) >> 14);
                den = (64'd1 << 30) + e;
                sigmoid_tab[i] = longint'(((64'd1 << 46) + (den >> 1)) / den);
            end
            ign_en = 0; ign_val = -1; mode = NORM_BATCH; batch = 1;
            per_sample = 1; weight = 256;
            sum = 0; count = 0; norm = 1; errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
            case (idx)
                REG_IGNORE_ENABLE:    ign_en = d[0];
                REG_IGNORE_VALUE:     ign_val = d[8:0];
                REG_NORM_MODE:        mode = d[1:0];
                REG_BATCH_SIZE:       batch = d;
                REG_PER_SAMPLE_COUNT: per_sample = d;
                REG_GRAD_WEIGHT:      weight = d;
                default: ;
            endcase
        endfunction

        function longint round_div(longint n, longint d);
            longint m, q;
            m = (n < 0) ? -n : n;
            q = (m + d / 2) / d;
            return (n < 0) ? -q : q;
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Called for every accepted input word.
        function void note_input(logic act, logic signed [15:0] x_in,
                                 logic signed [15:0] y_in, logic lst);
            longint x, y, ax, idx, sp, sg, term, n, diff, g;
            bit pos, ign;
            loss_word_t w;
            x = x_in;
            y = y_in;
            pos = (x >= 0);
            ax = pos ? x : -x;
            idx = (ax * ROM_DEPTH) >>> 12;
            sp = 0;
            sg = 65536;
            ign = ign_en && ((y / 256) == longint'(ign_val));
            if (idx < ROM_DEPTH)
            begin
                sp = softplus_tab[idx];
                sg = sigmoid_tab[idx];
            end
            if (!pos) sg = 65536 - sg;
            if (act == ACT_FWD)
            begin
                if (!ign)
                begin
                    term = x * ((pos ? 256 : 0) - y) + sp;
                    sum += term;
                    if (sum > (64'sd1 << 47) - 1) sum = (64'sd1 << 47) - 1;
                    if (sum < -(64'sd1 << 47)) sum = -(64'sd1 << 47);
                    if (count < MAX_ELEM) count++;
                end
                if (!lst) return;
                case (mode)
                    NORM_FULL:  n = longint'(batch) * longint'(per_sample);
                    NORM_VALID: n = count;
                    NORM_BATCH: n = longint'(batch);
                    default:    n = 1;
                endcase
                if (n < 1) n = 1;
                norm = n;
                w.kind = KIND_LOSS;
                w.value = clip32(round_div(sum, n));
                w.final_res = 1'b1;
                sum = 0;
                count = 0;
            end
            else
            begin
                g = 0;
                if (!ign)
                begin
                    diff = sg - y * 256;
                    g = round_div(diff * longint'(weight), norm << 8);
                end
                w.kind = KIND_GRAD;
                w.value = clip32(g);
                w.final_res = 1'b0;
            end
            expected_words.insert(expected_words.size(), w);
        endfunction

        // Called for every accepted output word.
        function void check(logic k, logic signed [31:0] v, logic f);
            loss_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word: kind %0d value %0d final_res %0d", k, v, f);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (k !== w.kind)
            begin
                $error("kind: expected %0d, actual %0d", w.kind, k);
                errors++;
            end
            if (v !== w.value)
            begin
                $error("value: expected %0d, actual %0d", w.value, v);
                errors++;
            end
            if (f !== w.final_res)
            begin
                $error("final_res: expected %0d, actual %0d", w.final_res, f);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  action = 1'b0;
    logic signed [15:0]    logit = '0;
    logic signed [15:0]    target = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic signed [31:0]    value;
    logic                  final_res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    loss_scoreboard sb = new();

    // Idle percentages for each side, and a long receiver hold-off counter.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    sigmoid_cross_entropy_loss_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .logit(logit), .target(target), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .value(value), .final_res(final_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver: checks each accepted output word and decides the stall for
    // the next cycle. A pending hold-off keeps the stall high throughout.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check(kind, value, final_res);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offers one word and waits until the block takes it. in_valid is left
    // high, so back-to-back words never lower and raise it in the same step.
    task automatic send_word(logic act, logic signed [15:0] x,
                             logic signed [15:0] y, logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        logit <= x;
        target <= y;
        last <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(act, x, y, lst);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // A forward word without a result may still be in the pipeline.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    // Writes every register; only called while the block is idle.
    task automatic program_regs(logic ie, logic signed [8:0] iv, logic [1:0] nm,
                                logic [15:0] bs, logic [15:0] pc,
                                logic signed [15:0] lw);
        write_reg(REG_IGNORE_ENABLE, {15'd0, ie});
        write_reg(REG_IGNORE_VALUE, {{7{iv[8]}}, iv});
        write_reg(REG_NORM_MODE, {14'd0, nm});
        write_reg(REG_BATCH_SIZE, bs);
        write_reg(REG_PER_SAMPLE_COUNT, pc);
        write_reg(REG_GRAD_WEIGHT, lw);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Logits: mostly inside the table range, sometimes anywhere.
    function automatic logic signed [15:0] pick_logit();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return $signed(16'($urandom_range(4600))) - 16'sd2300;
    endfunction

    // Targets: labels near 0 and 1, the ignore label, or anything at all.
    function automatic logic signed [15:0] pick_target();
        longint base, y;
        int frac;
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'sd256 : 16'sd0;
            1: return $signed(16'($urandom_range(600))) - 16'sd172;
            2:
            begin
                base = longint'(sb.ign_val) * 256;
                frac = $urandom_range(255);
                y = (base >= 0) ? base + frac : base - frac;
                if (y >= -32768 && y <= 32767) return y[15:0];
                if (base >= -32768 && base <= 32767) return base[15:0];
                return 16'($urandom);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed passes: a few forward words closed by a last word,
    // with backward words mixed in, each carrying a random, stray last bit.
    task automatic random_words(int n_words);
        int left;
        int run;
        left = n_words;
        while (left > 0)
        begin
            run = $urandom_range(6, 1);
            for (int i = 0; i < run; i++)
            begin
                while ($urandom_range(99) < 40)
                begin
                    send_word(ACT_BWD, pick_logit(), pick_target(), 1'($urandom_range(1)));
                    left--;
                end
                send_word(ACT_FWD, pick_logit(), pick_target(), i == run - 1);
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings. The first one is a
        // backward word before any pass, so it uses a normalizer of one.
        send_word(ACT_BWD, 16'sd100, 16'sd0, 1'b0);
        send_word(ACT_BWD, -16'sd32768, 16'sd32767, 1'b1);
        send_word(ACT_FWD, 16'sd0, 16'sd0, 1'b0);
        send_word(ACT_FWD, 16'sd32767, -16'sd32768, 1'b0);
        send_word(ACT_FWD, -16'sd32768, 16'sd32767, 1'b1);
        send_word(ACT_BWD, 16'sd4096, 16'sd256, 1'b0);
        send_word(ACT_BWD, -16'sd5000, 16'sd0, 1'b0);
        drain();

        // Ignore on with label -1; a zero valid count must become one, and the
        // weight is at its negative extreme. The unmapped index must do nothing.
        program_regs(1'b1, -9'sd1, NORM_VALID, 16'd0, 16'd0, -16'sd32768);
        write_reg(REG_UNMAPPED, 16'hffff);
        cfg_valid <= 1'b0;
        send_word(ACT_FWD, 16'sd300, -16'sd200, 1'b0);
        send_word(ACT_FWD, 16'sd300, -16'sd256, 1'b0);
        send_word(ACT_FWD, 16'sd10, -16'sd300, 1'b1);
        send_word(ACT_BWD, 16'sd50, -16'sd511, 1'b0);
        send_word(ACT_BWD, 16'sd50, 16'sd100, 1'b0);
        send_word(ACT_FWD, 16'sd20, -16'sd256, 1'b1);
        send_word(ACT_BWD, 16'sd20, 16'sd0, 1'b0);
        drain();

        program_regs(1'b0, 9'sd0, NORM_FULL, 16'd65535, 16'd65535, 16'sd32767);
        send_word(ACT_FWD, -16'sd4095, 16'sd256, 1'b1);
        send_word(ACT_BWD, 16'sd7, -16'sd32768, 1'b0);
        drain();

        // Random phases: two per idling pattern, each with new settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 71 : 0;
            recv_stall_pct = (ph < 2) ? 71 : (ph < 4) ? 9 : 0;
            case (ph)
                0: program_regs(1'b1, 9'sd255, NORM_NONE, 16'd3, 16'd4, 16'sd256);
                1: program_regs(1'b1, -9'sd256, NORM_BATCH, 16'd65535, 16'd2, -16'sd256);
                2: program_regs(1'b1, 9'sd0, NORM_VALID, 16'd8, 16'd8, 16'sd32767);
                default: program_regs(1'($urandom_range(1)), 9'($urandom),
                                      2'($urandom_range(3)),
                                      16'($urandom_range(40, 1)),
                                      16'($urandom_range(40, 1)), 16'($urandom));
            endcase
            if (ph == 4)
                hold_left = 400;   // the queue fills and the input stalls
            random_words(50);
            if (ph == 5)
            begin
                // Let the block empty completely before going on.
                in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            random_words(50);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_sigmoid_cross_entropy_loss_top passed");
        else
            $display("tb_sigmoid_cross_entropy_loss_top failed");
        $finish;
    end

    initial
    begin
        #(8 * 1000000);
        $display("tb_sigmoid_cross_entropy_loss_top failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/sce_pkg.sv
design/sce_front.sv
design/sce_rom.sv
design/sce_div.sv
design/sce_back.sv
design/sigmoid_cross_entropy_loss_top.sv
verif/tb_sigmoid_cross_entropy_loss_top.sv
